// ----- sv/luhn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared types and constants for the card number check block.
// ----------------------------------------------------------------------------
package luhn_pkg;

    // input word and decimal layout
    localparam int NUM_BITS    = 64;
    localparam int DIGIT_W     = 4;
    localparam int DIGIT_SLOTS = 20;
    localparam int BCD_W       = DIGIT_SLOTS * DIGIT_W;
    localparam int COUNT_W     = 5;
    localparam int STEP_W      = $clog2(NUM_BITS);
    localparam int POS_W       = $clog2(DIGIT_SLOTS);

    // most digits that still get a check
    localparam int MAX_DIGITS = 19;

    // result classes
    localparam logic [1:0] KIND_INVALID = 2'd0;
    localparam logic [1:0] KIND_AMX     = 2'd1;
    localparam logic [1:0] KIND_MC      = 2'd2;
    localparam logic [1:0] KIND_V       = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } t_state;

endpackage

// ----- sv/luhn_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_in_if / luhn_out_if
// Valid/ready channels for the card number and for the check result.
// ----------------------------------------------------------------------------
interface luhn_in_if;
    logic                          valid;
    logic                          ready;
    logic [luhn_pkg::NUM_BITS-1:0] card_number;

    modport source (output valid, output card_number, input ready);
    modport sink   (input valid, input card_number, output ready);
endinterface

interface luhn_out_if;
    logic                         valid;
    logic                         ready;
    logic                         luhn_ok;
    logic [1:0]                   card_kind;
    logic [luhn_pkg::COUNT_W-1:0] digit_count;

    modport source (output valid, output luhn_ok, output card_kind, output digit_count,
                    input ready);
    modport sink   (input valid, input luhn_ok, input card_kind, input digit_count,
                    output ready);
endinterface

// ----- sv/luhn_card_number_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_card_number_check
// Flow: the 64-step shift-add-3 converter turns the input beat to decimal,
// then a 20-digit scan and a classify step form the result.
// One card number at a time: a new one is taken once the output beat is taken.
// Reset: synchronous active-low, returns to idle and drops the output beat.
// Converts the binary number to decimal with one shift-add-3 unit, then walks
// the digits through one adder to form the mod-10 sum, count and prefix.
// ----------------------------------------------------------------------------
module luhn_card_number_check #(
    parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    luhn_in_if.sink          i_card,
    luhn_out_if.source       o_res
);

    luhn_pkg::t_state r_state, n_state;

    logic [luhn_pkg::NUM_BITS-1:0] r_bin, n_bin;
    logic [luhn_pkg::BCD_W-1:0]    r_bcd, n_bcd;
    logic [luhn_pkg::STEP_W-1:0]   r_step, n_step;
    logic [luhn_pkg::DIGIT_W-1:0]  r_sum, n_sum;
    logic [luhn_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [luhn_pkg::DIGIT_W-1:0]  r_lead, n_lead;
    logic [luhn_pkg::DIGIT_W-1:0]  r_next, n_next;
    logic [luhn_pkg::DIGIT_W-1:0]  r_prev, n_prev;
    logic                          r_ok, n_ok;
    logic [1:0]                    r_kind, n_kind;

    logic [luhn_pkg::BCD_W-1:0]    w_adj;
    logic [luhn_pkg::DIGIT_W-1:0]  w_dig;
    logic [luhn_pkg::DIGIT_W:0]    w_add;
    logic [luhn_pkg::POS_W-1:0]    w_pos;
    logic                          w_fits;
    logic                          w_pass;
    logic [1:0]                    w_class;

    // add-3 correction on every decimal digit before the shift
    always_comb begin
        logic [luhn_pkg::DIGIT_W-1:0] dg;
        for (int i = 0; i < luhn_pkg::DIGIT_SLOTS; i++) begin
            dg = r_bcd[i*luhn_pkg::DIGIT_W +: luhn_pkg::DIGIT_W];
            w_adj[i*luhn_pkg::DIGIT_W +: luhn_pkg::DIGIT_W] =
                (dg >= 4'd5) ? dg + 4'd3 : dg;
        end
    end

    // shared digit adder: double every second digit, fold, add mod ten
    assign w_pos = r_step[luhn_pkg::POS_W-1:0];
    assign w_dig = r_bcd[luhn_pkg::DIGIT_W-1:0];
    always_comb begin
        logic [luhn_pkg::DIGIT_W:0] dd;
        logic [luhn_pkg::DIGIT_W:0] s;
        dd = {1'b0, w_dig};
        if (w_pos[0]) begin
            dd = {w_dig, 1'b0};
            if (dd > 5'd9) begin
                dd = dd - 5'd9;
            end
        end
        s = {1'b0, r_sum} + dd;
        if (s >= 5'd10) begin
            s = s - 5'd10;
        end
        w_add = s;
    end

    // length check and prefix classes
    assign w_fits = (r_count <= luhn_pkg::COUNT_W'(MAX_DIGITS));
    assign w_pass = w_fits && (r_sum == '0);
    always_comb begin
        w_class = luhn_pkg::KIND_INVALID;
        if (r_count == 5'd15 && r_lead == 4'd3 && (r_next == 4'd4 || r_next == 4'd7)) begin
            w_class = luhn_pkg::KIND_AMX;
        end else if (r_count == 5'd16 && r_lead == 4'd5 && (r_next inside {[4'd1:4'd5]})) begin
            w_class = luhn_pkg::KIND_MC;
        end else if ((r_count inside {5'd13, 5'd16}) && r_lead == 4'd4) begin
            w_class = luhn_pkg::KIND_V;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= luhn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_step  <= n_step;
        r_sum   <= n_sum;
        r_count <= n_count;
        r_lead  <= n_lead;
        r_next  <= n_next;
        r_prev  <= n_prev;
        r_ok    <= n_ok;
        r_kind  <= n_kind;
    end

    // sequencer: next state and datapath control
    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_step  = r_step;
        n_sum   = r_sum;
        n_count = r_count;
        n_lead  = r_lead;
        n_next  = r_next;
        n_prev  = r_prev;
        n_ok    = r_ok;
        n_kind  = r_kind;
        case (r_state)
            luhn_pkg::ST_IDLE: begin
                if (i_card.valid) begin
                    n_bin   = i_card.card_number;
                    n_bcd   = '0;
                    n_step  = '0;
                    n_state = luhn_pkg::ST_CONV;
                end
            end
            luhn_pkg::ST_CONV: begin
                n_bcd  = {w_adj[luhn_pkg::BCD_W-2:0], r_bin[luhn_pkg::NUM_BITS-1]};
                n_bin  = {r_bin[luhn_pkg::NUM_BITS-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == luhn_pkg::STEP_W'(luhn_pkg::NUM_BITS - 1)) begin
                    n_step  = '0;
                    n_sum   = '0;
                    n_count = '0;
                    n_lead  = '0;
                    n_next  = '0;
                    n_prev  = '0;
                    n_state = luhn_pkg::ST_SCAN;
                end
            end
            luhn_pkg::ST_SCAN: begin
                n_sum  = w_add[luhn_pkg::DIGIT_W-1:0];
                n_prev = w_dig;
                if (w_dig != '0) begin
                    n_count = luhn_pkg::COUNT_W'(w_pos) + 1'b1;
                    n_lead  = w_dig;
                    n_next  = r_prev;
                end
                n_bcd  = {{luhn_pkg::DIGIT_W{1'b0}}, r_bcd[luhn_pkg::BCD_W-1:luhn_pkg::DIGIT_W]};
                n_step = r_step + 1'b1;
                if (w_pos == luhn_pkg::POS_W'(luhn_pkg::DIGIT_SLOTS - 1)) begin
                    n_state = luhn_pkg::ST_FINISH;
                end
            end
            luhn_pkg::ST_FINISH: begin
                n_ok    = w_pass;
                n_kind  = (w_pass && r_count >= 5'd2) ? w_class : luhn_pkg::KIND_INVALID;
                n_state = luhn_pkg::ST_DONE;
            end
            luhn_pkg::ST_DONE: begin
                if (o_res.ready) begin
                    n_state = luhn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = luhn_pkg::ST_IDLE;
            end
        endcase
    end

    // channel outputs
    assign i_card.ready      = (r_state == luhn_pkg::ST_IDLE);
    assign o_res.valid       = (r_state == luhn_pkg::ST_DONE);
    assign o_res.luhn_ok     = r_ok;
    assign o_res.card_kind   = r_kind;
    assign o_res.digit_count = r_count;

    // a classified number always passed the check
    a_kind_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.card_kind != luhn_pkg::KIND_INVALID) |-> o_res.luhn_ok)
        else $error("card class given without a passing check");

    // count never exceeds the digit slots
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.digit_count <= luhn_pkg::COUNT_W'(luhn_pkg::DIGIT_SLOTS)))
        else $error("digit count out of range");

    // an accepted beat starts the converter from step zero
    a_start_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_card.valid && i_card.ready) |=> (r_state == luhn_pkg::ST_CONV && r_step == '0))
        else $error("converter did not start after input beat");

    // the 15-digit class only comes with a 15-digit count
    a_kind_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.card_kind == luhn_pkg::KIND_AMX) |-> (o_res.digit_count == 5'd15))
        else $error("class does not match length");

    // no new input while a result is pending
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_card.ready && o_res.valid))
        else $error("input open while result pending");

endmodule
